/* hdl/sfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial frame receiver package
// Shared types, constants and the byte classifier of the frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int HEADER_BYTES = 9;
  localparam int IN_DEPTH     = 4;
  localparam int OUT_DEPTH    = 4;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 16;

  localparam logic [7:0] SYNC_FIRST  = 8'hAB;
  localparam logic [7:0] SYNC_SECOND = 8'hBA;

  localparam logic [15:0] RESPONSE_TIMEOUT_RST = 16'd1000;
  localparam logic [15:0] MAX_BODY_LEN_RST     = 16'd256;

  localparam logic [CFG_IDX_W-1:0] REG_RESPONSE_TIMEOUT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BODY_LEN     = CFG_IDX_W'(1);

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic KIND_BODY = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CKSUM    = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_TIMEOUT  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    PH_HUNT1  = 4'd0,
    PH_HUNT2  = 4'd1,
    PH_LEN_LO = 4'd2,
    PH_LEN_HI = 4'd3,
    PH_SRC    = 4'd4,
    PH_DEST   = 4'd5,
    PH_CMD    = 4'd6,
    PH_IDX_LO = 4'd7,
    PH_IDX_HI = 4'd8,
    PH_BODY   = 4'(HEADER_BYTES),
    PH_CK_LO  = 4'(HEADER_BYTES + 1),
    PH_CK_HI  = 4'(HEADER_BYTES + 2)
  } phase_e;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  body_byte;
    logic [7:0]  src_id;
    logic [7:0]  dest_id;
    logic [7:0]  cmd_code;
    logic [15:0] frame_index;
    logic [15:0] frame_len;
    logic [1:0]  status;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic       is_tick;
    logic       is_sync1;
    logic       is_sync2;
    logic [7:0] data;
  } front_word_t;

  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_write_t;

  function automatic front_word_t classify(input in_word_t w);
    front_word_t f;
    f.is_tick  = (w.req_type == REQ_TICK);
    f.is_sync1 = (w.rx_byte == SYNC_FIRST);
    f.is_sync2 = (w.rx_byte == SYNC_SECOND);
    f.data     = w.rx_byte;
    return f;
  endfunction

endpackage

/* hdl/sfr_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame receiver queue
// Small first-in first-out register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module sfr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* hdl/sfr_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame receiver parser
// Frame state machine: sync hunt, header capture, body pass-through,
// length and checksum checks, tick timeout, two configuration registers.
// ----------------------------------------------------------------------------
module sfr_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  sfr_pkg::front_word_t in_word_i,
  output logic                in_pop_o,
  input  logic                out_ready_i,
  output logic                out_push_o,
  output sfr_pkg::out_word_t  out_word_o,
  input  sfr_pkg::cfg_write_t cfg_i
);

  sfr_pkg::phase_e phase_q, phase_d;
  logic [15:0] timeout_q, timeout_d;
  logic [15:0] max_len_q, max_len_d;
  logic [15:0] len_q, len_d;
  logic [15:0] left_q, left_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  src_q, src_d;
  logic [7:0]  dest_q, dest_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] index_q, index_d;
  logic [7:0]  ck_low_q, ck_low_d;
  logic [15:0] ticks_q, ticks_d;

  logic        fire;
  logic        res_valid;
  logic        res_kind;
  logic [7:0]  res_byte;
  sfr_pkg::status_e res_status;
  logic        over_len;
  logic [15:0] len_full;
  logic [15:0] left_dec;

  assign fire     = in_valid_i && out_ready_i;
  assign in_pop_o = fire;
  assign over_len = (len_q > max_len_q);
  assign len_full = {in_word_i.data, len_q[7:0]};
  assign left_dec = left_q - 16'd1;

  always_comb begin
    timeout_d = timeout_q;
    max_len_d = max_len_q;
    if (cfg_i.valid) begin
      if (cfg_i.index == sfr_pkg::REG_RESPONSE_TIMEOUT) begin
        timeout_d = cfg_i.data;
      end else if (cfg_i.index == sfr_pkg::REG_MAX_BODY_LEN) begin
        max_len_d = cfg_i.data;
      end
    end
  end

  always_comb begin
    phase_d    = phase_q;
    len_d      = len_q;
    left_d     = left_q;
    sum_d      = sum_q;
    src_d      = src_q;
    dest_d     = dest_q;
    cmd_d      = cmd_q;
    index_d    = index_q;
    ck_low_d   = ck_low_q;
    ticks_d    = ticks_q;
    res_valid  = 1'b0;
    res_kind   = sfr_pkg::KIND_BODY;
    res_byte   = 8'h00;
    res_status = sfr_pkg::ST_OK;
    if (fire) begin
      if (in_word_i.is_tick) begin
        if (phase_q == sfr_pkg::PH_HUNT1) begin
          ticks_d = timeout_q;
        end else if (ticks_q <= 16'd1) begin
          res_valid  = 1'b1;
          res_kind   = sfr_pkg::KIND_END;
          res_status = sfr_pkg::ST_TIMEOUT;
          phase_d    = sfr_pkg::PH_HUNT1;
          ticks_d    = timeout_q;
        end else begin
          ticks_d = ticks_q - 16'd1;
        end
      end else begin
        if (phase_q >= sfr_pkg::PH_LEN_LO && phase_q <= sfr_pkg::PH_BODY) begin
          sum_d = sum_q + {8'h00, in_word_i.data};
        end
        unique case (phase_q)
          sfr_pkg::PH_HUNT1: begin
            if (in_word_i.is_sync1) begin
              len_d    = '0;
              left_d   = '0;
              sum_d    = '0;
              src_d    = '0;
              dest_d   = '0;
              cmd_d    = '0;
              index_d  = '0;
              ck_low_d = '0;
              ticks_d  = timeout_q;
              phase_d  = sfr_pkg::PH_HUNT2;
            end
          end
          sfr_pkg::PH_HUNT2: begin
            if (in_word_i.is_sync2) begin
              phase_d = sfr_pkg::PH_LEN_LO;
            end else if (!in_word_i.is_sync1) begin
              phase_d = sfr_pkg::PH_HUNT1;
            end
          end
          sfr_pkg::PH_LEN_LO: begin
            len_d   = {8'h00, in_word_i.data};
            phase_d = sfr_pkg::PH_LEN_HI;
          end
          sfr_pkg::PH_LEN_HI: begin
            len_d   = len_full;
            left_d  = len_full;
            phase_d = sfr_pkg::PH_SRC;
          end
          sfr_pkg::PH_SRC: begin
            src_d   = in_word_i.data;
            phase_d = sfr_pkg::PH_DEST;
          end
          sfr_pkg::PH_DEST: begin
            dest_d  = in_word_i.data;
            phase_d = sfr_pkg::PH_CMD;
          end
          sfr_pkg::PH_CMD: begin
            cmd_d   = in_word_i.data;
            phase_d = sfr_pkg::PH_IDX_LO;
          end
          sfr_pkg::PH_IDX_LO: begin
            index_d = {8'h00, in_word_i.data};
            phase_d = sfr_pkg::PH_IDX_HI;
          end
          sfr_pkg::PH_IDX_HI: begin
            index_d = {in_word_i.data, index_q[7:0]};
            phase_d = (left_q == '0) ? sfr_pkg::PH_CK_LO : sfr_pkg::PH_BODY;
          end
          sfr_pkg::PH_BODY: begin
            left_d = left_dec;
            if (left_dec == '0) begin
              phase_d = sfr_pkg::PH_CK_LO;
            end
            if (!over_len) begin
              res_valid = 1'b1;
              res_byte  = in_word_i.data;
            end
          end
          sfr_pkg::PH_CK_LO: begin
            ck_low_d = in_word_i.data;
            phase_d  = sfr_pkg::PH_CK_HI;
          end
          sfr_pkg::PH_CK_HI: begin
            res_valid = 1'b1;
            res_kind  = sfr_pkg::KIND_END;
            if (over_len) begin
              res_status = sfr_pkg::ST_TOO_LONG;
            end else if ({in_word_i.data, ck_low_q} != (16'd0 - sum_q)) begin
              res_status = sfr_pkg::ST_CKSUM;
            end
            phase_d = sfr_pkg::PH_HUNT1;
            ticks_d = timeout_q;
          end
          default: begin
            phase_d = sfr_pkg::PH_HUNT1;
          end
        endcase
      end
    end
  end

  always_comb begin
    out_push_o             = res_valid;
    out_word_o.kind        = res_kind;
    out_word_o.body_byte   = res_byte;
    out_word_o.src_id      = src_q;
    out_word_o.dest_id     = dest_q;
    out_word_o.cmd_code    = cmd_q;
    out_word_o.frame_index = index_q;
    out_word_o.frame_len   = len_q;
    out_word_o.status      = res_status;
    out_word_o.last        = res_kind;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= sfr_pkg::PH_HUNT1;
      timeout_q <= sfr_pkg::RESPONSE_TIMEOUT_RST;
      max_len_q <= sfr_pkg::MAX_BODY_LEN_RST;
      len_q     <= '0;
      left_q    <= '0;
      sum_q     <= '0;
      src_q     <= '0;
      dest_q    <= '0;
      cmd_q     <= '0;
      index_q   <= '0;
      ck_low_q  <= '0;
      ticks_q   <= sfr_pkg::RESPONSE_TIMEOUT_RST;
    end else begin
      phase_q   <= phase_d;
      timeout_q <= timeout_d;
      max_len_q <= max_len_d;
      len_q     <= len_d;
      left_q    <= left_d;
      sum_q     <= sum_d;
      src_q     <= src_d;
      dest_q    <= dest_d;
      cmd_q     <= cmd_d;
      index_q   <= index_d;
      ck_low_q  <= ck_low_d;
      ticks_q   <= ticks_d;
    end
  end

endmodule

/* hdl/serial_frame_receiver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial frame receiver
// Deframer for sync/length framed serial data with a 16-bit checksum and a
// tick driven receive timeout.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  input     in         push / full           in_word_i  (req_type, rx_byte)
//  result    out        empty / pop           out_word_o (kind ... last)
//  config    in         cfg_valid_i / ready   cfg_index_i, cfg_data_i
//
// One word is taken every clock cycle while the input queue is not full;
// the frame state machine retires one word per cycle from the input queue
// while the result queue is not full. Each word's result is registered in
// the result queue. Reset empties both queues.
// A full result queue halts the state machine; the input queue then fills
// and raises full.
// ----------------------------------------------------------------------------
module serial_frame_receiver #(
  parameter int IN_DEPTH  = sfr_pkg::IN_DEPTH,
  parameter int OUT_DEPTH = sfr_pkg::OUT_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  sfr_pkg::in_word_t              in_word_i,
  output logic                           empty,
  input  logic                           pop,
  output sfr_pkg::out_word_t             out_word_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int FW = $bits(sfr_pkg::front_word_t);
  localparam int OW = $bits(sfr_pkg::out_word_t);

  sfr_pkg::front_word_t front_in, front_out;
  sfr_pkg::out_word_t   res_word;
  sfr_pkg::cfg_write_t  cfg;
  logic                 front_empty, front_pop;
  logic                 res_full, res_push;

  assign front_in    = sfr_pkg::classify(in_word_i);
  assign cfg_ready_o = 1'b1;
  assign cfg.valid   = cfg_valid_i;
  assign cfg.index   = cfg_index_i;
  assign cfg.data    = cfg_data_i;

  sfr_fifo #(
    .WIDTH(FW),
    .DEPTH(IN_DEPTH)
  ) u_in_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_in),
    .full_o (full),
    .pop_i  (front_pop),
    .data_o (front_out),
    .empty_o(front_empty)
  );

  sfr_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (!front_empty),
    .in_word_i  (front_out),
    .in_pop_o   (front_pop),
    .out_ready_i(!res_full),
    .out_push_o (res_push),
    .out_word_o (res_word),
    .cfg_i      (cfg)
  );

  sfr_fifo #(
    .WIDTH(OW),
    .DEPTH(OUT_DEPTH)
  ) u_out_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_word),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (out_word_o),
    .empty_o(empty)
  );

endmodule

/* hdl/sfr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame receiver checker
// Port level checks on the result side of the frame receiver.
// ----------------------------------------------------------------------------
module sfr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input sfr_pkg::out_word_t out_word_o
);

  a_last_matches_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_word_o.last == out_word_o.kind))
    else $error("last differs from kind");

  a_body_status_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_word_o.kind == sfr_pkg::KIND_BODY) |->
      (out_word_o.status == sfr_pkg::ST_OK))
    else $error("body word carries a status");

  a_end_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_word_o.kind == sfr_pkg::KIND_END) |-> (out_word_o.body_byte == 8'h00))
    else $error("frame end word carries a body byte");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_word_o)))
    else $error("waiting result changed");

endmodule

bind serial_frame_receiver sfr_checker u_sfr_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .empty     (empty),
  .pop       (pop),
  .out_word_o(out_word_o)
);

/* verif/tb_serial_frame_receiver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial frame receiver testbench
// Drives received bytes and timer ticks into the frame receiver, predicts
// every body byte and frame status with a cycle-free deframer model kept
// alongside, and checks each popped result word field by field. Covers the
// sync hunt, the checksum, over-length and timeout endings and both
// registers under changing sender and receiver stalls.
// ----------------------------------------------------------------------------
module tb_serial_frame_receiver;

  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam logic [sfr_pkg::CFG_IDX_W-1:0] REG_NONE = sfr_pkg::CFG_IDX_W'(2);

  logic                           clk_i;
  logic                           rst_ni;
  logic                           push;
  logic                           full;
  sfr_pkg::in_word_t              in_word_i;
  logic                           empty;
  logic                           pop;
  sfr_pkg::out_word_t             out_word_o;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data_i;

  sfr_pkg::phase_e rx_phase;
  logic [15:0] decl_len;
  logic [15:0] body_left;
  logic [15:0] lrc_sum;
  logic [15:0] hdr_index;
  logic [15:0] ticks_left;
  logic [15:0] cfg_timeout;
  logic [15:0] cfg_max_len;
  logic [7:0]  hdr_src;
  logic [7:0]  hdr_dest;
  logic [7:0]  hdr_cmd;
  logic [7:0]  ck_low;

  sfr_pkg::out_word_t pending_results[$];
  int unsigned n_fail        = 0;
  int unsigned items_sent    = 0;
  int unsigned send_idle_pct = 32;
  int unsigned recv_idle_pct = 55;
  int unsigned stall_cycles  = 0;

  serial_frame_receiver DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_word_i   (in_word_i),
    .empty       (empty),
    .pop         (pop),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic sfr_pkg::out_word_t frame_result(input logic kind,
                                                      input logic [7:0] b,
                                                      input sfr_pkg::status_e st);
    sfr_pkg::out_word_t r;
    r.kind        = kind;
    r.body_byte   = b;
    r.src_id      = hdr_src;
    r.dest_id     = hdr_dest;
    r.cmd_code    = hdr_cmd;
    r.frame_index = hdr_index;
    r.frame_len   = decl_len;
    r.status      = st;
    r.last        = kind;
    return r;
  endfunction

  function automatic void advance_receiver(input sfr_pkg::in_word_t w);
    logic [7:0]       b;
    logic [15:0]      got_ck;
    sfr_pkg::status_e st;
    b = w.rx_byte;
    if (w.req_type == sfr_pkg::REQ_TICK) begin
      if (rx_phase == sfr_pkg::PH_HUNT1) begin
        ticks_left = cfg_timeout;
      end else if (ticks_left <= 16'd1) begin
        pending_results.push_back(frame_result(sfr_pkg::KIND_END, 8'h00,
                                               sfr_pkg::ST_TIMEOUT));
        rx_phase   = sfr_pkg::PH_HUNT1;
        ticks_left = cfg_timeout;
      end else begin
        ticks_left = ticks_left - 16'd1;
      end
    end else begin
      if (rx_phase >= sfr_pkg::PH_LEN_LO && rx_phase <= sfr_pkg::PH_BODY) begin
        lrc_sum = lrc_sum + {8'h00, b};
      end
      case (rx_phase)
        sfr_pkg::PH_HUNT1: begin
          if (b == sfr_pkg::SYNC_FIRST) begin
            decl_len   = '0;
            body_left  = '0;
            lrc_sum    = '0;
            hdr_src    = '0;
            hdr_dest   = '0;
            hdr_cmd    = '0;
            hdr_index  = '0;
            ck_low     = '0;
            ticks_left = cfg_timeout;
            rx_phase   = sfr_pkg::PH_HUNT2;
          end
        end
        sfr_pkg::PH_HUNT2: begin
          if (b == sfr_pkg::SYNC_SECOND) begin
            rx_phase = sfr_pkg::PH_LEN_LO;
          end else if (b != sfr_pkg::SYNC_FIRST) begin
            rx_phase = sfr_pkg::PH_HUNT1;
          end
        end
        sfr_pkg::PH_LEN_LO: begin
          decl_len = {8'h00, b};
          rx_phase = sfr_pkg::PH_LEN_HI;
        end
        sfr_pkg::PH_LEN_HI: begin
          decl_len[15:8] = b;
          body_left      = decl_len;
          rx_phase       = sfr_pkg::PH_SRC;
        end
        sfr_pkg::PH_SRC: begin
          hdr_src  = b;
          rx_phase = sfr_pkg::PH_DEST;
        end
        sfr_pkg::PH_DEST: begin
          hdr_dest = b;
          rx_phase = sfr_pkg::PH_CMD;
        end
        sfr_pkg::PH_CMD: begin
          hdr_cmd  = b;
          rx_phase = sfr_pkg::PH_IDX_LO;
        end
        sfr_pkg::PH_IDX_LO: begin
          hdr_index = {8'h00, b};
          rx_phase  = sfr_pkg::PH_IDX_HI;
        end
        sfr_pkg::PH_IDX_HI: begin
          hdr_index[15:8] = b;
          rx_phase        = (body_left == 16'd0) ? sfr_pkg::PH_CK_LO : sfr_pkg::PH_BODY;
        end
        sfr_pkg::PH_BODY: begin
          body_left = body_left - 16'd1;
          if (body_left == 16'd0) begin
            rx_phase = sfr_pkg::PH_CK_LO;
          end
          if (decl_len <= cfg_max_len) begin
            pending_results.push_back(frame_result(sfr_pkg::KIND_BODY, b,
                                                   sfr_pkg::ST_OK));
          end
        end
        sfr_pkg::PH_CK_LO: begin
          ck_low   = b;
          rx_phase = sfr_pkg::PH_CK_HI;
        end
        sfr_pkg::PH_CK_HI: begin
          got_ck = {b, ck_low};
          if (decl_len > cfg_max_len) begin
            st = sfr_pkg::ST_TOO_LONG;
          end else if (got_ck != 16'h0000 - lrc_sum) begin
            st = sfr_pkg::ST_CKSUM;
          end else begin
            st = sfr_pkg::ST_OK;
          end
          pending_results.push_back(frame_result(sfr_pkg::KIND_END, 8'h00, st));
          rx_phase   = sfr_pkg::PH_HUNT1;
          ticks_left = cfg_timeout;
        end
        default: begin
          rx_phase = sfr_pkg::PH_HUNT1;
        end
      endcase
    end
  endfunction

  function automatic void cmp_field(input string name, input logic [15:0] want,
                                    input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      n_fail++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    sfr_pkg::out_word_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          $error("result word popped with none expected");
          n_fail++;
        end else begin
          want = pending_results.pop_front();
          cmp_field("kind", 16'(want.kind), 16'(out_word_o.kind));
          cmp_field("body_byte", 16'(want.body_byte), 16'(out_word_o.body_byte));
          cmp_field("src_id", 16'(want.src_id), 16'(out_word_o.src_id));
          cmp_field("dest_id", 16'(want.dest_id), 16'(out_word_o.dest_id));
          cmp_field("cmd_code", 16'(want.cmd_code), 16'(out_word_o.cmd_code));
          cmp_field("frame_index", want.frame_index, out_word_o.frame_index);
          cmp_field("frame_len", want.frame_len, out_word_o.frame_len);
          cmp_field("status", 16'(want.status), 16'(out_word_o.status));
          cmp_field("last", 16'(want.last), 16'(out_word_o.last));
        end
      end
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("serial_frame_receiver test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_word(input sfr_pkg::in_word_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (full);
    advance_receiver(w);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(sfr_pkg::in_word_t'{req_type: sfr_pkg::REQ_BYTE, rx_byte: b});
  endtask

  task automatic send_tick();
    send_word(sfr_pkg::in_word_t'{req_type: sfr_pkg::REQ_TICK, rx_byte: 8'($urandom)});
  endtask

  task automatic finish_frame();
    while (rx_phase != sfr_pkg::PH_HUNT1) begin
      if (rx_phase == sfr_pkg::PH_BODY && ticks_left <= body_left) begin
        send_tick();
      end else begin
        send_byte(8'h00);
      end
    end
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [sfr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sfr_pkg::CFG_DATA_W-1:0] data);
    finish_frame();
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == sfr_pkg::REG_RESPONSE_TIMEOUT) begin
      cfg_timeout = data;
    end else if (idx == sfr_pkg::REG_MAX_BODY_LEN) begin
      cfg_max_len = data;
    end
  endtask

  task automatic send_frame(input logic [15:0] len, input logic [7:0] src,
                            input logic [7:0] dest, input logic [7:0] cmd,
                            input logic [15:0] idx, input bit corrupt,
                            input bit twice_sync, input int unsigned tick_pct,
                            input int unsigned cut);
    logic [7:0]  frame_q[$];
    logic [15:0] sum;
    logic [15:0] ck;
    logic [7:0]  b;
    frame_q = {};
    if (twice_sync) begin
      frame_q.push_back(sfr_pkg::SYNC_FIRST);
    end
    frame_q.push_back(sfr_pkg::SYNC_FIRST);
    frame_q.push_back(sfr_pkg::SYNC_SECOND);
    frame_q.push_back(len[7:0]);
    frame_q.push_back(len[15:8]);
    frame_q.push_back(src);
    frame_q.push_back(dest);
    frame_q.push_back(cmd);
    frame_q.push_back(idx[7:0]);
    frame_q.push_back(idx[15:8]);
    sum = len[7:0] + len[15:8] + src + dest + cmd + idx[7:0] + idx[15:8];
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      frame_q.push_back(b);
      sum = sum + b;
    end
    ck = 16'h0000 - sum;
    if (corrupt) begin
      ck = ck ^ 16'($urandom_range(1, 65535));
    end
    frame_q.push_back(ck[7:0]);
    frame_q.push_back(ck[15:8]);
    for (int i = 0; i < frame_q.size() && i < cut; i++) begin
      if ($urandom_range(0, 99) < tick_pct) begin
        send_tick();
      end
      send_byte(frame_q[i]);
    end
  endtask

  task automatic test_reset_defaults();
    send_tick();
    send_byte(sfr_pkg::SYNC_FIRST);
    send_byte(8'h00);
    send_frame(16'd0, 8'hFF, 8'h00, 8'hFF, 16'hFFFF, 1'b0, 1'b1, 0, 100);
  endtask

  task automatic test_over_length();
    write_reg(sfr_pkg::REG_MAX_BODY_LEN, 16'd0);
    write_reg(REG_NONE, 16'($urandom));
    send_frame(16'd1, 8'h00, 8'hFF, 8'h00, 16'h0000, 1'b1, 1'b0, 0, 100);
  endtask

  task automatic test_timeout();
    write_reg(sfr_pkg::REG_RESPONSE_TIMEOUT, 16'd0);
    send_byte(sfr_pkg::SYNC_FIRST);
    send_byte(sfr_pkg::SYNC_SECOND);
    send_tick();
  endtask

  task automatic test_random_traffic(input int unsigned n_items, input logic [15:0] tmo,
                                     input logic [15:0] max_len,
                                     input int unsigned s_pct, input int unsigned r_pct);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned span;
    int unsigned cut;
    logic [15:0] len;
    logic [7:0]  b;
    bit          twice;
    write_reg(sfr_pkg::REG_RESPONSE_TIMEOUT, tmo);
    write_reg(sfr_pkg::REG_MAX_BODY_LEN, max_len);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick  = $urandom_range(0, 99);
      len   = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 40))
                                          : 16'($urandom_range(0, 12));
      twice = ($urandom_range(0, 5) == 0);
      span  = len + 11 + twice;
      cut   = span;
      if (pick >= 80 && pick < 90) begin
        cut = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(twice + 4, span - 1);
      end
      if (pick < 90) begin
        send_frame(len, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                   ($urandom_range(0, 5) == 0), twice,
                   ($urandom_range(0, 1) == 0) ? 0 : 10, cut);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 3) == 0) begin
            send_tick();
          end else begin
            b = 8'($urandom);
            if (b == sfr_pkg::SYNC_SECOND) begin
              b = sfr_pkg::SYNC_FIRST;
            end
            send_byte(b);
          end
        end
      end
    end
    finish_frame();
  endtask

  initial begin
    rst_ni      = 1'b0;
    push        = 1'b0;
    in_word_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    cfg_timeout = sfr_pkg::RESPONSE_TIMEOUT_RST;
    cfg_max_len = sfr_pkg::MAX_BODY_LEN_RST;
    rx_phase    = sfr_pkg::PH_HUNT1;
    decl_len    = '0;
    body_left   = '0;
    lrc_sum     = '0;
    hdr_src     = '0;
    hdr_dest    = '0;
    hdr_cmd     = '0;
    hdr_index   = '0;
    ck_low      = '0;
    ticks_left  = sfr_pkg::RESPONSE_TIMEOUT_RST;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_over_length();
    test_timeout();
    test_random_traffic(575, 16'd4, 16'd8, 32, 55);
    test_random_traffic(575, 16'hFFFF, 16'hFFFF, 55, 32);
    test_random_traffic(575, 16'($urandom_range(1, 40)), 16'($urandom_range(0, 15)), 0, 0);

    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("serial_frame_receiver test passed");
    end else begin
      $display("serial_frame_receiver test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/sfr_pkg.sv
hdl/sfr_fifo.sv
hdl/sfr_parser.sv
hdl/serial_frame_receiver.sv
hdl/sfr_checker.sv
verif/tb_serial_frame_receiver.sv
